FILE: rtl/sva_pkg.sv
package sva_pkg;

  // Widest voice index the VOICES range can need (up to 64 voices)
  localparam int IDX_W = 6;
  localparam int AGE_W = 32;
  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;

  // Request kinds
  localparam logic [1:0] REQ_ON = 2'd0;
  localparam logic [1:0] REQ_OFF = 2'd1;
  localparam logic [1:0] REQ_ALL_OFF = 2'd2;
  localparam logic [1:0] REQ_FINISHED = 2'd3;

  // Result actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_RETARGET = 2'd2;
  localparam logic [1:0] ACT_NOTHING = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MONO = 2'd0;
  localparam logic [1:0] REG_POLY = 2'd1;
  localparam logic [1:0] REG_GLIDE = 2'd2;

  localparam int VOICES_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RMV,
    ST_MON,
    ST_MOFF,
    ST_PON,
    ST_FIN
  } st_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_PULL
  } stk_op_t;

  // Write command shared by all voice cells
  typedef struct packed {
    logic              busy_set;
    logic              busy_clr;
    logic              note_wr;
    logic              age_wr;
    logic [NOTE_W-1:0] note;
    logic [AGE_W-1:0]  age;
  } vc_wr_t;

  // Stored state a voice cell shows
  typedef struct packed {
    logic              busy;
    logic [NOTE_W-1:0] note;
  } vc_st_t;

  // Running search handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] fidx;
    logic             hasmin;
    logic [AGE_W-1:0] age;
    logic [IDX_W-1:0] midx;
  } vc_link_t;

  typedef struct packed {
    logic [1:0]        act;
    logic [3:0]        voice;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              slide;
  } res_t;

endpackage

FILE: rtl/sva_voice_cell.sv
module sva_voice_cell import sva_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  vc_wr_t           wr,
  input  logic [IDX_W-1:0] last,
  input  vc_link_t         link_i,
  output vc_link_t         link_o,
  output vc_st_t           st_o
);

  logic             busy_r;
  logic [NOTE_W-1:0] note_r;
  logic [AGE_W-1:0] age_r;
  vc_link_t         link_r;
  vc_link_t         link_nxt;
  logic             in_range;

  // Hold voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      note_r <= '0;
      age_r  <= '0;
    end else if (wr_en) begin
      if (wr.busy_set) busy_r <= 1'b1;
      else if (wr.busy_clr) busy_r <= 1'b0;
      if (wr.note_wr) note_r <= wr.note;
      if (wr.age_wr) age_r <= wr.age;
    end
  end

  assign in_range = (IDX >= 1) && (IDX_W'(IDX) <= last);

  // Fold this voice into the first-idle and oldest search
  always_comb begin
    link_nxt = link_i;
    if (in_range && !busy_r && !link_i.found) begin
      link_nxt.found = 1'b1;
      link_nxt.fidx  = IDX_W'(IDX);
    end
    if (in_range && (!link_i.hasmin || age_r < link_i.age)) begin
      link_nxt.hasmin = 1'b1;
      link_nxt.age    = age_r;
      link_nxt.midx   = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) link_r <= '0;
    else link_r <= link_nxt;
  end

  assign link_o = link_r;
  assign st_o.busy = busy_r;
  assign st_o.note = note_r;

endmodule

FILE: rtl/sva_stack_cell.sv
module sva_stack_cell import sva_pkg::*; (
  input  logic              clk,
  input  stk_op_t           op,
  input  logic              pull,
  input  logic [NOTE_W-1:0] below,
  input  logic [NOTE_W-1:0] above,
  output logic [NOTE_W-1:0] q
);

  logic [NOTE_W-1:0] note_r;

  // Shift toward the bottom on push, close the gap on pull
  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH: note_r <= below;
      STK_PULL: if (pull) note_r <= above;
      default: note_r <= note_r;
    endcase
  end

  assign q = note_r;

endmodule

FILE: rtl/synth_voice_allocator_unit.sv
// Each event runs a scan over all voices; the idle/oldest search ripples through the
// voice cell chain one cell per cycle.
// Events are taken only in idle; results leave one per cycle while out_tready is high.
// Reset: rst_n synchronous active low clears voices, stack count, age counter
// and registers to their defaults (mono off, polyphony 8, glide off).
module synth_voice_allocator_unit import sva_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // note[6:0], velocity[13:7], voice_id[17:14], zero pad
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // voice[3:0], target_note[10:4], note_velocity[17:11],
                                  // slide[18], zero pad
  output logic [1:0]  out_tuser,  // action[1:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int HW = $clog2(VOICES + 1);

  st_t              state_r, state_nxt;
  logic [VW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       typ_r, typ_nxt;
  logic [NOTE_W-1:0] nt_r, nt_nxt;
  logic [VEL_W-1:0] vel_r, vel_nxt;
  logic [3:0]       vid_r, vid_nxt;
  logic [HW-1:0]    hc_r, hc_nxt;
  logic [AGE_W-1:0] age_cnt_r, age_cnt_nxt;
  logic [VEL_W-1:0] mvel_r, mvel_nxt;
  logic             we_r, we_nxt;
  logic             mono_r, glide_r;
  logic [4:0]       poly_r;
  logic             pend_v_r, pend_v_nxt;
  res_t             pend_r, pend_nxt;
  logic             out_v_r, out_v_nxt;
  res_t             out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  logic             gen, ok, out_free, wen_any;
  res_t             gres;
  logic [IDX_W-1:0] sel, last, pick;
  vc_wr_t           vc_wr;
  logic [VOICES-1:0] vc_wen;
  vc_link_t         link [VOICES+1];
  vc_st_t           st [VOICES];
  stk_op_t          stk_op;
  logic [NOTE_W-1:0] stk [VOICES];
  logic [VOICES-1:0] hit, sh;
  logic             emit, mcond;
  vc_st_t           cur;

  // Clamp polyphony into the usable poly range
  always_comb begin
    if (poly_r == 5'd0) last = IDX_W'(1);
    else if (IDX_W'(poly_r) > IDX_W'(VOICES - 1)) last = IDX_W'(VOICES - 1);
    else last = IDX_W'(poly_r);
  end

  assign link[0] = '0;

  genvar g;
  generate
    for (g = 0; g < VOICES; g++) begin : g_voice
      sva_voice_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n), .wr_en(vc_wen[g]), .wr(vc_wr), .last(last),
        .link_i(link[g]), .link_o(link[g+1]), .st_o(st[g])
      );
    end
    for (g = 0; g < VOICES; g++) begin : g_stack
      sva_stack_cell u_stk (
        .clk(clk), .op(stk_op), .pull(sh[g]),
        .below((g == 0) ? nt_r : stk[(g == 0) ? 0 : g-1]),
        .above((g == VOICES-1) ? stk[g] : stk[(g == VOICES-1) ? g : g+1]),
        .q(stk[g])
      );
    end
  endgenerate

  assign pick = link[VOICES].found ? link[VOICES].fidx : link[VOICES].midx;

  // Locate the note in the stack and mark the cells that close the gap
  always_comb begin
    for (int k = 0; k < VOICES; k++) begin
      hit[k] = (HW'(k) < hc_r) && (stk[k] == nt_r);
    end
    for (int k = 0; k < VOICES; k++) begin
      sh[k] = |(hit & ((VOICES)'(2) << k) - (VOICES)'(1)) | hit[k];
    end
  end

  assign cur = st[cnt_r];
  assign mcond = (hc_r != '0) || (st[0].busy && st[0].note == nt_r);
  assign emit = ((typ_r == REQ_OFF) && (cnt_r != '0) && cur.busy && (cur.note == nt_r)) ||
                ((typ_r == REQ_ALL_OFF) && cur.busy);
  assign out_free = !out_v_r || out_tready;
  assign ok = !pend_v_r || out_free;

  // Sequence one event
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    typ_nxt = typ_r;
    nt_nxt = nt_r;
    vel_nxt = vel_r;
    vid_nxt = vid_r;
    hc_nxt = hc_r;
    age_cnt_nxt = age_cnt_r;
    mvel_nxt = mvel_r;
    we_nxt = we_r;
    gen = 1'b0;
    gres = '0;
    wen_any = 1'b0;
    sel = '0;
    vc_wr = '0;
    vc_wr.age = age_cnt_r;
    vc_wr.note = nt_r;
    stk_op = STK_HOLD;
    pend_v_nxt = pend_v_r;
    pend_nxt = pend_r;
    out_v_nxt = out_v_r;
    out_nxt = out_r;
    out_last_nxt = out_last_r;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          typ_nxt = ((in_tuser == REQ_ON) && (in_tdata[13:7] == '0)) ? REQ_OFF : in_tuser;
          nt_nxt = in_tdata[6:0];
          vel_nxt = in_tdata[13:7];
          vid_nxt = in_tdata[17:14];
          cnt_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!emit || ok) begin
          gen = emit;
          gres.act = ACT_RELEASE;
          gres.voice = 4'(IDX_W'(cnt_r));
          gres.note = cur.note;
          if (cnt_r == VW'(VOICES - 1)) begin
            case (typ_r)
              REQ_ON: begin
                we_nxt = (hc_r == '0);
                state_nxt = mono_r ? ST_RMV : ST_PON;
              end
              REQ_OFF: state_nxt = mcond ? ST_RMV : ST_FIN;
              REQ_ALL_OFF: begin
                hc_nxt = '0;
                state_nxt = ST_FIN;
              end
              default: begin
                wen_any = 1'b1;
                sel = IDX_W'(vid_r);
                vc_wr.busy_clr = 1'b1;
                state_nxt = ST_FIN;
              end
            endcase
          end else begin
            cnt_nxt = cnt_r + VW'(1);
          end
        end
      end
      ST_RMV: begin
        stk_op = STK_PULL;
        if (|hit) hc_nxt = hc_r - HW'(1);
        state_nxt = (typ_r == REQ_ON) ? ST_MON : ST_MOFF;
      end
      ST_MON: begin
        if (ok) begin
          gen = 1'b1;
          stk_op = STK_PUSH;
          if (hc_r != HW'(VOICES)) hc_nxt = hc_r + HW'(1);
          wen_any = 1'b1;
          vc_wr.note_wr = 1'b1;
          mvel_nxt = vel_r;
          gres.note = nt_r;
          gres.vel = vel_r;
          if (we_r) begin
            vc_wr.busy_set = 1'b1;
            vc_wr.age_wr = 1'b1;
            age_cnt_nxt = age_cnt_r + AGE_W'(1);
            gres.act = ACT_START;
          end else begin
            gres.act = ACT_RETARGET;
            gres.slide = glide_r;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_MOFF: begin
        if (st[0].note != nt_r) begin
          state_nxt = ST_FIN;
        end else if (ok) begin
          gen = 1'b1;
          if (hc_r == '0) begin
            gres.act = ACT_RELEASE;
            gres.note = st[0].note;
          end else begin
            wen_any = 1'b1;
            vc_wr.note_wr = 1'b1;
            vc_wr.note = stk[0];
            gres.act = ACT_RETARGET;
            gres.note = stk[0];
            gres.vel = mvel_r;
            gres.slide = glide_r;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_PON: begin
        if (ok) begin
          gen = 1'b1;
          wen_any = 1'b1;
          sel = pick;
          vc_wr.busy_set = 1'b1;
          vc_wr.note_wr = 1'b1;
          vc_wr.age_wr = 1'b1;
          age_cnt_nxt = age_cnt_r + AGE_W'(1);
          gres.act = ACT_START;
          gres.voice = pick[3:0];
          gres.note = nt_r;
          gres.vel = vel_r;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_last_nxt = 1'b1;
          if (pend_v_r) out_nxt = pend_r;
          else begin
            out_nxt = '0;
            out_nxt.act = ACT_NOTHING;
          end
          pend_v_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Move the older result out once a newer one shows up
    if (gen) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt = gres;
    end
  end

  // Select the written voice cell
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      vc_wen[i] = wen_any && (IDX_W'(i) == sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hc_r <= '0;
      age_cnt_r <= '0;
      mvel_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      mono_r <= 1'b0;
      poly_r <= 5'd8;
      glide_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hc_r <= hc_nxt;
      age_cnt_r <= age_cnt_nxt;
      mvel_r <= mvel_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_MONO: mono_r <= cfg_data[0];
          REG_POLY: poly_r <= cfg_data;
          REG_GLIDE: glide_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload holds
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    typ_r <= typ_nxt;
    nt_r <= nt_nxt;
    vel_r <= vel_nxt;
    vid_r <= vid_nxt;
    we_r <= we_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tuser = out_r.act;
  assign out_tlast = out_last_r;
  assign out_tdata = {5'd0, out_r.slide, out_r.vel, out_r.note, out_r.voice};

`ifndef SYNTH
  a_nothing_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_NOTHING |-> out_tlast)
    else $error("idle result not marked last");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HW'(VOICES))
    else $error("stack count overflow");
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second event taken during work");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    gen && pend_v_r |-> out_free)
    else $error("result register overwritten");
`endif

endmodule
